// ----- hdl/hsl_to_rgb_converter_assert.svh -----
// ----------------------------------------------------------------------------
// hsl to rgb converter assertion macros
// concurrent check wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef HSL_TO_RGB_CONVERTER_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_ASSERT_SVH
`ifndef SYNTHESIS
// check outside reset only
`define HSLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// check on every edge, reset included
`define HSLC_ASSERT_AR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define HSLC_ASSERT(lbl, prop, msg)
`define HSLC_ASSERT_AR(lbl, prop, msg)
`endif
`endif

// ----- hdl/hslc_pkg.sv -----
// ----------------------------------------------------------------------------
// hslc package
// widths, fixed-point constants, percent table and stage types
// ----------------------------------------------------------------------------
package hslc_pkg;

  localparam int unsigned FRAC_BITS = 16;

  // port field widths
  localparam int unsigned HUE_W = 13;
  localparam int unsigned PCT_W = 7;
  localparam int unsigned CH_W  = 8;

  // fixed point: values up to one inclusive
  localparam int unsigned UNIT_W = FRAC_BITS + 1;
  localparam logic [UNIT_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // hue sectors
  localparam int unsigned SECTOR_UNITS = 960;
  localparam int unsigned SECTOR_LAST  = ((1 << HUE_W) - 1) / SECTOR_UNITS;
  localparam int unsigned SECTOR_W     = $clog2(SECTOR_LAST + 1);
  localparam int unsigned WEIGHT_W     = $clog2(SECTOR_UNITS + 1);

  localparam logic [SECTOR_W-1:0] SEC_RED     = SECTOR_W'(0);
  localparam logic [SECTOR_W-1:0] SEC_YELLOW  = SECTOR_W'(1);
  localparam logic [SECTOR_W-1:0] SEC_GREEN   = SECTOR_W'(2);
  localparam logic [SECTOR_W-1:0] SEC_CYAN    = SECTOR_W'(3);
  localparam logic [SECTOR_W-1:0] SEC_BLUE    = SECTOR_W'(4);
  localparam logic [SECTOR_W-1:0] SEC_MAGENTA = SECTOR_W'(5);

  // chroma times sector weight, then divide by 960 = 64 * 15
  localparam int unsigned PROD_W    = UNIT_W + WEIGHT_W;
  localparam int unsigned DIV_SHIFT = 6;
  localparam int unsigned DIV_ODD   = 15;
  localparam int unsigned QW        = PROD_W - DIV_SHIFT;
  localparam int unsigned RECIP_SH  = QW + 4;
  localparam int unsigned RW        = QW + 1;
  localparam logic [RW-1:0] RECIP =
    RW'(((64'd1 << RECIP_SH) + DIV_ODD - 1) / DIV_ODD);

  // percent to fixed point, clamped at full scale
  localparam int unsigned PCT_FULL  = 100;
  localparam int unsigned PCT_DEPTH = 1 << PCT_W;

  typedef logic [UNIT_W-1:0] pct_lut_t [PCT_DEPTH];

  function automatic pct_lut_t build_pct_lut();
    pct_lut_t        lut;
    longint unsigned p;
    for (int i = 0; i < PCT_DEPTH; i++) begin
      p = (i > PCT_FULL) ? PCT_FULL : i;
      lut[i] = UNIT_W'((p << FRAC_BITS) / PCT_FULL);
    end
    return lut;
  endfunction

  localparam pct_lut_t PCT_LUT = build_pct_lut();

  // decode stage result
  typedef struct packed {
    logic [UNIT_W-1:0]   sat;
    logic [UNIT_W-1:0]   light;
    logic [SECTOR_W-1:0] sector;
    logic [WEIGHT_W-1:0] weight;
  } dec_t;

  // chroma stage result
  typedef struct packed {
    logic [PROD_W-1:0]   prod;
    logic [UNIT_W-1:0]   chroma;
    logic [UNIT_W-1:0]   offset;
    logic [SECTOR_W-1:0] sector;
  } blend_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

endpackage

// ----- hdl/hslc_hsl_if.sv -----
// ----------------------------------------------------------------------------
// hslc hsl channel
// valid/ready request carrying one hsl pixel
// ----------------------------------------------------------------------------
interface hslc_hsl_if;
  logic                         valid;
  logic                         ready;
  logic [hslc_pkg::HUE_W-1:0]   hue;
  logic [hslc_pkg::PCT_W-1:0]   saturation;
  logic [hslc_pkg::PCT_W-1:0]   lightness;

  modport source (output valid, output hue, output saturation, output lightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input lightness,
                  output ready);
endinterface

// ----- hdl/hslc_rgb_if.sv -----
// ----------------------------------------------------------------------------
// hslc rgb channel
// valid/ready request carrying one rgb pixel
// ----------------------------------------------------------------------------
interface hslc_rgb_if;
  logic                        valid;
  logic                        ready;
  logic [hslc_pkg::CH_W-1:0]   red;
  logic [hslc_pkg::CH_W-1:0]   green;
  logic [hslc_pkg::CH_W-1:0]   blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ----- hdl/hslc_decode.sv -----
// ----------------------------------------------------------------------------
// hslc decode stage
// percent lookup and hue sector / weight, one register stage
// ----------------------------------------------------------------------------
module hslc_decode (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [hslc_pkg::HUE_W-1:0] hue_i,
  input  logic [hslc_pkg::PCT_W-1:0] saturation_i,
  input  logic [hslc_pkg::PCT_W-1:0] lightness_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output hslc_pkg::dec_t             out_data_o
);

  logic                                 valid_q;
  hslc_pkg::dec_t                       data_d, data_q;
  logic [hslc_pkg::SECTOR_W-1:0]        sector;
  logic [hslc_pkg::HUE_W-1:0]           base;
  logic [hslc_pkg::HUE_W-1:0]           rem_full;
  logic [hslc_pkg::WEIGHT_W-1:0]        rem;

  // sector = hue / 960 by parallel compares
  always_comb begin
    sector = '0;
    for (int k = 1; k <= hslc_pkg::SECTOR_LAST; k++) begin
      if (hue_i >= hslc_pkg::HUE_W'(k * hslc_pkg::SECTOR_UNITS)) begin
        sector = sector + 1'b1;
      end
    end
  end

  assign base     = hslc_pkg::HUE_W'(sector * hslc_pkg::SECTOR_UNITS);
  assign rem_full = hue_i - base;
  assign rem      = rem_full[hslc_pkg::WEIGHT_W-1:0];

  // weight is 960 - |hue mod 1920 - 960|
  always_comb begin
    data_d.sat    = hslc_pkg::PCT_LUT[saturation_i];
    data_d.light  = hslc_pkg::PCT_LUT[lightness_i];
    data_d.sector = sector;
    data_d.weight = sector[0] ? hslc_pkg::WEIGHT_W'(hslc_pkg::SECTOR_UNITS) - rem : rem;
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ----- hdl/hslc_chroma.sv -----
// ----------------------------------------------------------------------------
// hslc chroma stages
// chroma from saturation and lightness, then chroma times weight and offset
// ----------------------------------------------------------------------------
module hslc_chroma (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  hslc_pkg::dec_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output hslc_pkg::blend_t out_data_o
);

  typedef struct packed {
    logic [hslc_pkg::UNIT_W-1:0]   chroma;
    logic [hslc_pkg::UNIT_W-1:0]   light;
    logic [hslc_pkg::SECTOR_W-1:0] sector;
    logic [hslc_pkg::WEIGHT_W-1:0] weight;
  } chr_t;

  logic                              a_valid_q, b_valid_q;
  logic                              a_ready, b_ready;
  chr_t                              a_d, a_q;
  hslc_pkg::blend_t                  b_d, b_q;
  logic [hslc_pkg::UNIT_W:0]         twol;
  logic [hslc_pkg::UNIT_W:0]         dist_full;
  logic [hslc_pkg::UNIT_W-1:0]       one_minus_t;
  logic [2*hslc_pkg::UNIT_W-1:0]     sat_prod;
  logic [hslc_pkg::UNIT_W-1:0]       half;

  // stage a: c = s * (1 - |2l - 1|)
  assign twol      = {in_data_i.light, 1'b0};
  assign dist_full = (twol >= {1'b0, hslc_pkg::ONE}) ? twol - {1'b0, hslc_pkg::ONE}
                                                     : {1'b0, hslc_pkg::ONE} - twol;
  assign one_minus_t = hslc_pkg::ONE - dist_full[hslc_pkg::UNIT_W-1:0];
  assign sat_prod    = (2*hslc_pkg::UNIT_W)'(in_data_i.sat)
                     * (2*hslc_pkg::UNIT_W)'(one_minus_t);

  always_comb begin
    a_d.chroma = sat_prod[hslc_pkg::FRAC_BITS +: hslc_pkg::UNIT_W];
    a_d.light  = in_data_i.light;
    a_d.sector = in_data_i.sector;
    a_d.weight = in_data_i.weight;
  end

  // stage b: c * weight and m = l - c/2 floored at zero
  assign half = a_q.chroma >> 1;

  always_comb begin
    b_d.prod   = hslc_pkg::PROD_W'(a_q.chroma) * hslc_pkg::PROD_W'(a_q.weight);
    b_d.chroma = a_q.chroma;
    b_d.offset = (a_q.light >= half) ? a_q.light - half : '0;
    b_d.sector = a_q.sector;
  end

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= in_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_q <= a_d;
    end
    if (b_ready && a_valid_q) begin
      b_q <= b_d;
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_data_o  = b_q;

endmodule

// ----- hdl/hslc_mix.sv -----
// ----------------------------------------------------------------------------
// hslc mix stages
// divide by sector width, place components, scale to 8-bit channels
// ----------------------------------------------------------------------------
module hslc_mix (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  hslc_pkg::blend_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output hslc_pkg::rgb_t   out_data_o
);

  localparam int unsigned SUM_W   = hslc_pkg::UNIT_W + 1;
  localparam int unsigned SCALE_W = SUM_W + hslc_pkg::CH_W;
  localparam int unsigned HI_W    = SCALE_W - hslc_pkg::FRAC_BITS;
  localparam int unsigned RP_W    = hslc_pkg::QW + hslc_pkg::RW;

  typedef struct packed {
    logic [hslc_pkg::UNIT_W-1:0]   chroma;
    logic [hslc_pkg::UNIT_W-1:0]   sec_x;
    logic [hslc_pkg::UNIT_W-1:0]   offset;
    logic [hslc_pkg::SECTOR_W-1:0] sector;
  } comp_t;

  // floor(255 * v) >> frac, saturated
  function automatic logic [hslc_pkg::CH_W-1:0] to_channel(
    input logic [SUM_W-1:0] v
  );
    logic [SCALE_W-1:0] scaled;
    logic [HI_W-1:0]    hi;
    scaled = {v, {hslc_pkg::CH_W{1'b0}}} - SCALE_W'(v);
    hi     = scaled[SCALE_W-1:hslc_pkg::FRAC_BITS];
    return (hi > HI_W'({hslc_pkg::CH_W{1'b1}})) ? {hslc_pkg::CH_W{1'b1}}
                                                  : hi[hslc_pkg::CH_W-1:0];
  endfunction

  logic                                      c_valid_q, d_valid_q;
  logic                                      c_ready, d_ready;
  comp_t                                     c_d, c_q;
  hslc_pkg::rgb_t                            d_d, d_q;
  logic [hslc_pkg::QW-1:0]                   quot_in;
  logic [RP_W-1:0]                           recip_prod;
  logic [hslc_pkg::UNIT_W-1:0]               rc, gc, bc;

  // stage c: x = prod / 960 = (prod >> 6) / 15 by reciprocal
  assign quot_in    = in_data_i.prod[hslc_pkg::PROD_W-1:hslc_pkg::DIV_SHIFT];
  assign recip_prod = RP_W'(quot_in) * RP_W'(hslc_pkg::RECIP);

  always_comb begin
    c_d.chroma = in_data_i.chroma;
    c_d.sec_x  = recip_prod[hslc_pkg::RECIP_SH +: hslc_pkg::UNIT_W];
    c_d.offset = in_data_i.offset;
    c_d.sector = in_data_i.sector;
  end

  // stage d: place c and x by sector, gray above the last sector
  always_comb begin
    rc = '0;
    gc = '0;
    bc = '0;
    unique case (c_q.sector)
      hslc_pkg::SEC_RED: begin
        rc = c_q.chroma;
        gc = c_q.sec_x;
      end
      hslc_pkg::SEC_YELLOW: begin
        rc = c_q.sec_x;
        gc = c_q.chroma;
      end
      hslc_pkg::SEC_GREEN: begin
        gc = c_q.chroma;
        bc = c_q.sec_x;
      end
      hslc_pkg::SEC_CYAN: begin
        gc = c_q.sec_x;
        bc = c_q.chroma;
      end
      hslc_pkg::SEC_BLUE: begin
        rc = c_q.sec_x;
        bc = c_q.chroma;
      end
      hslc_pkg::SEC_MAGENTA: begin
        rc = c_q.chroma;
        bc = c_q.sec_x;
      end
      default: begin
        rc = '0;
      end
    endcase
  end

  always_comb begin
    d_d.red   = to_channel({1'b0, c_q.offset} + {1'b0, rc});
    d_d.green = to_channel({1'b0, c_q.offset} + {1'b0, gc});
    d_d.blue  = to_channel({1'b0, c_q.offset} + {1'b0, bc});
  end

  assign d_ready    = !d_valid_q || out_ready_i;
  assign c_ready    = !c_valid_q || d_ready;
  assign in_ready_o = c_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      if (c_ready) begin
        c_valid_q <= in_valid_i;
      end
      if (d_ready) begin
        d_valid_q <= c_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && in_valid_i) begin
      c_q <= c_d;
    end
    if (d_ready && c_valid_q) begin
      d_q <= d_d;
    end
  end

  assign out_valid_o = d_valid_q;
  assign out_data_o  = d_q;

endmodule

// ----- hdl/hsl_to_rgb_converter.sv -----
// ----------------------------------------------------------------------------
// hsl to rgb converter
// five-stage pipeline turning an hsl pixel into 8-bit red, green and blue
// ----------------------------------------------------------------------------
// channel  dir  handshake     payload
// hsl_i    in   valid/ready   hue[12:0], saturation[6:0], lightness[6:0]
// rgb_o    out  valid/ready   red[7:0], green[7:0], blue[7:0]
//
// one request per clock sustained while rgb_o is ready; decode, chroma, mix in turn
// the two multiplies and the reciprocal divide each get a stage of their own
// rst_ni clears every stage valid bit asynchronously, payload is not reset
// a stalled output backs up stage by stage, empty stages still take data
// hsl_i.ready drops only when all five stages hold a pixel and rgb_o stalls
// ----------------------------------------------------------------------------
`include "hsl_to_rgb_converter_assert.svh"

module hsl_to_rgb_converter (
  input  logic       clk_i,
  input  logic       rst_ni,
  hslc_hsl_if.sink   hsl_i,
  hslc_rgb_if.source rgb_o
);

  // decode -> chroma
  logic             dec_valid;
  logic             dec_ready;
  hslc_pkg::dec_t   dec_data;

  // chroma -> mix
  logic             chr_valid;
  logic             chr_ready;
  hslc_pkg::blend_t chr_data;

  hslc_pkg::rgb_t   pix;

  // stage 1: percent table and hue sector
  hslc_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (hsl_i.valid),
    .in_ready_o   (hsl_i.ready),
    .hue_i        (hsl_i.hue),
    .saturation_i (hsl_i.saturation),
    .lightness_i  (hsl_i.lightness),
    .out_valid_o  (dec_valid),
    .out_ready_i  (dec_ready),
    .out_data_o   (dec_data)
  );

  // stages 2 and 3: chroma, weighted chroma and offset
  hslc_chroma u_chroma (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dec_valid),
    .in_ready_o  (dec_ready),
    .in_data_i   (dec_data),
    .out_valid_o (chr_valid),
    .out_ready_i (chr_ready),
    .out_data_o  (chr_data)
  );

  // stages 4 and 5: divide by sector width, channel placement, output register
  hslc_mix u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (chr_valid),
    .in_ready_o  (chr_ready),
    .in_data_i   (chr_data),
    .out_valid_o (rgb_o.valid),
    .out_ready_i (rgb_o.ready),
    .out_data_o  (pix)
  );

  assign rgb_o.red   = pix.red;
  assign rgb_o.green = pix.green;
  assign rgb_o.blue  = pix.blue;

  // no result shows while reset is held
  `HSLC_ASSERT_AR(rst_quiet_a, !rst_ni |-> !rgb_o.valid, "result valid during reset")
  // input backpressure only comes from a full pipe behind a stalled output
  `HSLC_ASSERT(stall_full_a, !hsl_i.ready |-> (rgb_o.valid && !rgb_o.ready), "input stalled while pipe has room")
  // an accepted request lands in the decode stage
  `HSLC_ASSERT(accept_lands_a, (hsl_i.valid && hsl_i.ready) |=> dec_valid, "accepted request lost at decode")
  // chroma stays within one
  `HSLC_ASSERT(chroma_range_a, chr_valid |-> (chr_data.chroma <= hslc_pkg::ONE), "chroma above one")

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// hsl to rgb converter testbench
// drives hsl pixels through the valid/ready channel with random gaps and
// output stalls, predicts unlisted rgb pixels in fixed point and compares fields
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  // cycles without any accepted request before the run is declared hung
  localparam int unsigned HANG_LIMIT   = 2000;
  // pipeline depth plus margin, waited out once everything has drained
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RANDOM_ITEMS = 1130;

  // one row of the directed pass: pixel in, and the pixel out where it is
  // obvious from the formulas (otherwise the predictor supplies it)
  typedef struct packed {
    logic [hslc_pkg::HUE_W-1:0] hue;
    logic [hslc_pkg::PCT_W-1:0] sat;
    logic [hslc_pkg::PCT_W-1:0] light;
    logic                       known;
    hslc_pkg::rgb_t             rgb;
  } hsl_row_t;

  localparam int unsigned DIRECTED_ROWS = 24;

  localparam hsl_row_t DIRECTED [DIRECTED_ROWS] = '{
    // fully saturated primaries and secondaries at sector starts
    '{13'd0,    7'd100, 7'd50,  1'b1, '{8'd255, 8'd0,   8'd0}},
    '{13'd960,  7'd100, 7'd50,  1'b1, '{8'd255, 8'd255, 8'd0}},
    '{13'd1920, 7'd100, 7'd50,  1'b1, '{8'd0,   8'd255, 8'd0}},
    '{13'd2880, 7'd100, 7'd50,  1'b1, '{8'd0,   8'd255, 8'd255}},
    '{13'd3840, 7'd100, 7'd50,  1'b1, '{8'd0,   8'd0,   8'd255}},
    '{13'd4800, 7'd100, 7'd50,  1'b1, '{8'd255, 8'd0,   8'd255}},
    // hue at and past a full turn: gray, no component in any channel
    '{13'd5760, 7'd100, 7'd50,  1'b1, '{8'd0,   8'd0,   8'd0}},
    '{13'd8191, 7'd0,   7'd50,  1'b1, '{8'd127, 8'd127, 8'd127}},
    // lightness extremes collapse the chroma
    '{13'd1000, 7'd100, 7'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{13'd2000, 7'd100, 7'd100, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{13'd0,    7'd0,   7'd50,  1'b1, '{8'd127, 8'd127, 8'd127}},
    // percents above full scale clamp to 100
    '{13'd8191, 7'd127, 7'd127, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{13'd3000, 7'd101, 7'd127, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{13'd4095, 7'd127, 7'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
    // sector edges and ramps, checked against the predictor
    '{13'd959,  7'd100, 7'd50,  1'b0, '0},
    '{13'd961,  7'd100, 7'd50,  1'b0, '0},
    '{13'd1919, 7'd100, 7'd50,  1'b0, '0},
    '{13'd4799, 7'd100, 7'd50,  1'b0, '0},
    '{13'd5759, 7'd100, 7'd50,  1'b0, '0},
    '{13'd1,    7'd100, 7'd51,  1'b0, '0},
    '{13'd100,  7'd100, 7'd99,  1'b0, '0},
    '{13'd7000, 7'd1,   7'd1,   1'b0, '0},
    '{13'd5000, 7'd37,  7'd73,  1'b0, '0},
    '{13'd2500, 7'd127, 7'd64,  1'b0, '0}
  };

  logic clk_i;
  logic rst_ni;

  hslc_hsl_if hsl_ch ();
  hslc_rgb_if rgb_ch ();

  hsl_to_rgb_converter DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hsl_i  (hsl_ch),
    .rgb_o  (rgb_ch)
  );

  // rgb pixels still owed by the converter, oldest first
  hslc_pkg::rgb_t rgb_pending_q [$];
  int unsigned    mismatch_count = 0;
  int unsigned    hung_cycles    = 0;
  int unsigned    sink_stall     = 0;
  // when set, neither side starts new gaps or stalls
  bit             steady_flow;

  // --------------------------------------------------------------------------
  // fixed-point prediction
  // --------------------------------------------------------------------------

  // whole percent to fixed point, clamped at full scale
  function automatic longint unsigned pct_fraction(
    input logic [hslc_pkg::PCT_W-1:0] pct
  );
    longint unsigned p;
    p = (pct > hslc_pkg::PCT_FULL) ? hslc_pkg::PCT_FULL : pct;
    return (p << hslc_pkg::FRAC_BITS) / hslc_pkg::PCT_FULL;
  endfunction

  // floor(255 * v), saturated to eight bits
  function automatic logic [hslc_pkg::CH_W-1:0] channel_level(input longint unsigned v);
    longint unsigned q;
    q = (255 * v) >> hslc_pkg::FRAC_BITS;
    return (q > 255) ? 8'd255 : q[hslc_pkg::CH_W-1:0];
  endfunction

  function automatic hslc_pkg::rgb_t hsl_to_rgb_expected(
    input logic [hslc_pkg::HUE_W-1:0] hue,
    input logic [hslc_pkg::PCT_W-1:0] sat_pct,
    input logic [hslc_pkg::PCT_W-1:0] light_pct
  );
    longint unsigned               full, sat, light, twice, spread, chroma, offset;
    longint unsigned               phase, tilt, second, red_c, green_c, blue_c;
    logic [hslc_pkg::SECTOR_W-1:0] sector;
    hslc_pkg::rgb_t                px;
    full   = longint'(1) << hslc_pkg::FRAC_BITS;
    sat    = pct_fraction(sat_pct);
    light  = pct_fraction(light_pct);
    twice  = 2 * light;
    spread = (twice >= full) ? twice - full : full - twice;
    chroma = (sat * (full - spread)) >> hslc_pkg::FRAC_BITS;
    offset = (light >= (chroma >> 1)) ? light - (chroma >> 1) : 0;
    // position within a two-sector period sets the secondary weight
    phase  = hue % (2 * hslc_pkg::SECTOR_UNITS);
    tilt   = (phase >= hslc_pkg::SECTOR_UNITS) ? phase - hslc_pkg::SECTOR_UNITS
                                               : hslc_pkg::SECTOR_UNITS - phase;
    second = (chroma * (hslc_pkg::SECTOR_UNITS - tilt)) / hslc_pkg::SECTOR_UNITS;
    sector = hslc_pkg::SECTOR_W'(hue / hslc_pkg::SECTOR_UNITS);
    red_c   = 0;
    green_c = 0;
    blue_c  = 0;
    case (sector)
      hslc_pkg::SEC_RED: begin
        red_c = chroma; green_c = second;
      end
      hslc_pkg::SEC_YELLOW: begin
        red_c = second; green_c = chroma;
      end
      hslc_pkg::SEC_GREEN: begin
        green_c = chroma; blue_c = second;
      end
      hslc_pkg::SEC_CYAN: begin
        green_c = second; blue_c = chroma;
      end
      hslc_pkg::SEC_BLUE: begin
        red_c = second; blue_c = chroma;
      end
      hslc_pkg::SEC_MAGENTA: begin
        red_c = chroma; blue_c = second;
      end
      default: ; // a full turn or more leaves plain gray
    endcase
    px.red   = channel_level(offset + red_c);
    px.green = channel_level(offset + green_c);
    px.blue  = channel_level(offset + blue_c);
    return px;
  endfunction

  // mostly back to back, sometimes a short gap, rarely a long break
  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // clock and reset
  // --------------------------------------------------------------------------

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // pixel source
  // --------------------------------------------------------------------------

  // present one pixel, hold it until accepted, then record what must come out
  task automatic send_pixel(input logic [hslc_pkg::HUE_W-1:0] hue,
                            input logic [hslc_pkg::PCT_W-1:0] sat,
                            input logic [hslc_pkg::PCT_W-1:0] light,
                            input logic                       known,
                            input hslc_pkg::rgb_t             rgb);
    int unsigned gap;
    gap = steady_flow ? 0 : idle_length();
    if (gap != 0) begin
      hsl_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    hsl_ch.valid      <= 1'b1;
    hsl_ch.hue        <= hue;
    hsl_ch.saturation <= sat;
    hsl_ch.lightness  <= light;
    do @(posedge clk_i); while (!hsl_ch.ready);
    rgb_pending_q.push_back(known ? rgb : hsl_to_rgb_expected(hue, sat, light));
  endtask

  // hold off new requests until the pipeline has handed back every pixel
  task automatic drain_pipeline();
    hsl_ch.valid <= 1'b0;
    while (rgb_pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_pixel();
    logic [hslc_pkg::HUE_W-1:0] hue;
    logic [hslc_pkg::PCT_W-1:0] sat;
    logic [hslc_pkg::PCT_W-1:0] light;
    int unsigned                kind;
    logic [hslc_pkg::PCT_W-1:0] pick [4];
    pick = '{7'd0, 7'd1, 7'd99, 7'd100};
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      // ordinary pixel within the valid ranges
      hue   = hslc_pkg::HUE_W'($urandom_range(0, 5759));
      sat   = hslc_pkg::PCT_W'($urandom_range(0, 100));
      light = hslc_pkg::PCT_W'($urandom_range(0, 100));
    end else if (kind == 7) begin
      // anything the fields can carry, clamped percents included
      hue   = hslc_pkg::HUE_W'($urandom_range(0, 8191));
      sat   = hslc_pkg::PCT_W'($urandom_range(0, 127));
      light = hslc_pkg::PCT_W'($urandom_range(0, 127));
    end else if (kind == 8) begin
      // past a full turn: gray
      hue   = hslc_pkg::HUE_W'($urandom_range(5760, 8191));
      sat   = hslc_pkg::PCT_W'($urandom_range(0, 127));
      light = hslc_pkg::PCT_W'($urandom_range(0, 100));
    end else begin
      // around a sector boundary with extreme percents
      hue   = hslc_pkg::HUE_W'($urandom_range(0, 6) * hslc_pkg::SECTOR_UNITS
                               + $urandom_range(0, 2));
      hue   = (hue == 0) ? hue : hue - 1'b1;
      sat   = pick[$urandom_range(0, 3)];
      light = pick[$urandom_range(0, 3)];
    end
    send_pixel(hue, sat, light, 1'b0, '0);
  endtask

  initial begin
    rst_ni            <= 1'b0;
    hsl_ch.valid      <= 1'b0;
    hsl_ch.hue        <= '0;
    hsl_ch.saturation <= '0;
    hsl_ch.lightness  <= '0;
    steady_flow        = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pass: extremes, every sector, clamping and gray
    foreach (DIRECTED[i])
      send_pixel(DIRECTED[i].hue, DIRECTED[i].sat, DIRECTED[i].light,
                 DIRECTED[i].known, DIRECTED[i].rgb);
    drain_pipeline();

    // random pass, in stretches that each run with or without gaps at random
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0)
        steady_flow = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_ITEMS / 2)
        drain_pipeline();
      send_random_pixel();
    end
    hsl_ch.valid <= 1'b0;

    while (rgb_pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // rgb sink: random stalls, no new ones while steady_flow is set
  // --------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (sink_stall != 0) begin
      rgb_ch.ready <= 1'b0;
      sink_stall    = sink_stall - 1;
    end else if (steady_flow || !rst_ni) begin
      rgb_ch.ready <= rst_ni;
    end else begin
      sink_stall    = idle_length();
      rgb_ch.ready <= (sink_stall == 0);
      if (sink_stall != 0)
        sink_stall = sink_stall - 1;
    end
  end

  // --------------------------------------------------------------------------
  // result check and hang watchdog
  // --------------------------------------------------------------------------

  always @(posedge clk_i) begin
    hslc_pkg::rgb_t want;
    if (rst_ni && rgb_ch.valid && rgb_ch.ready) begin
      if (rgb_pending_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected rgb %0d %0d %0d, nothing outstanding", $time,
                 rgb_ch.red, rgb_ch.green, rgb_ch.blue);
      end else begin
        want = rgb_pending_q.pop_front();
        if (rgb_ch.red !== want.red) begin
          mismatch_count++;
          $display("%0t: red expected %0d actual %0d", $time, want.red, rgb_ch.red);
        end
        if (rgb_ch.green !== want.green) begin
          mismatch_count++;
          $display("%0t: green expected %0d actual %0d", $time, want.green,
                   rgb_ch.green);
        end
        if (rgb_ch.blue !== want.blue) begin
          mismatch_count++;
          $display("%0t: blue expected %0d actual %0d", $time, want.blue, rgb_ch.blue);
        end
      end
    end

    // any accepted request on either channel counts as progress
    if ((hsl_ch.valid && hsl_ch.ready) || (rgb_ch.valid && rgb_ch.ready))
      hung_cycles = 0;
    else
      hung_cycles++;
    if (hung_cycles >= HANG_LIMIT) begin
      $display("%0t: no request accepted for %0d cycles", $time, HANG_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

endmodule
